// ----- hw/rtl/sporadic_server_budget_core_macros.svh -----
// Assertion macros shared by the sporadic server budget core modules.
// Expects clk and arst_n in the scope of each use.
`ifndef SPORADIC_SERVER_BUDGET_CORE_MACROS_SVH
`define SPORADIC_SERVER_BUDGET_CORE_MACROS_SVH

// same-cycle implication
`define SSB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ssb_pkg.sv -----
// Package for the sporadic server budget core: widths, reset values, codes
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ssb_pkg;

	localparam int TIME_W    = 63;
	localparam int AMT_W     = 32;
	localparam int DATA_W    = 32;
	localparam int CFG_AW    = 3;
	localparam int SLOTS_DEF = 8;

	localparam logic [AMT_W-1:0]  PERIOD_RST = 32'd3000;
	localparam logic [AMT_W-1:0]  BUDGET_RST = 32'd300;
	localparam logic [AMT_W-1:0]  AMT_MAX    = {AMT_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_COMPL   = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_INIT   = 1'b1;

	typedef struct packed {
		logic cap;
		logic fetch;
		logic scan;
		logic grant;
		logic compl;
		logic load_out;
	} ssb_cmd_t;

	typedef struct packed {
		logic eval_last;
	} ssb_stat_t;

endpackage

// ----- hw/rtl/ssb_if.sv -----
// Valid/ready channel interfaces for items and results of the budget core.
// Depends on ssb_pkg for field widths.
`timescale 1ns / 1ps

interface ssb_item_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [ssb_pkg::TIME_W-1:0]  now_time;
	logic [ssb_pkg::AMT_W-1:0]   amount;

	modport source (output valid, output opcode, output now_time, output amount, input ready);
	modport sink (input valid, input opcode, input now_time, input amount, output ready);
endinterface

interface ssb_result_if;
	logic                        valid;
	logic                        ready;
	logic                        granted;
	logic [ssb_pkg::AMT_W-1:0]   budget_left;
	logic                        refill_found;
	logic [ssb_pkg::TIME_W-1:0]  next_refill_time;
	logic [ssb_pkg::AMT_W-1:0]   next_refill_amount;
	logic                        budget_underflow;

	modport source (output valid, output granted, output budget_left, output refill_found,
		output next_refill_time, output next_refill_amount, output budget_underflow,
		input ready);
	modport sink (input valid, input granted, input budget_left, input refill_found,
		input next_refill_time, input next_refill_amount, input budget_underflow,
		output ready);
endinterface

// ----- hw/rtl/sporadic_server_budget_core.sv -----
// A request passes from its transfer to a valid result through a fetch state, a scan of each
// replenishment slot, since the slot memory is read at one address per cycle, a grant state
// and an output load; a completion passes through a completion state and the output load. The
// next item is taken in the cycle after the result is loaded, even while that result still
// waits on the output channel. replenish_period sits at byte address 0 and initial_budget at 4;
// the budget itself is loaded with 300 by reset only.
`timescale 1ns / 1ps

module sporadic_server_budget_core #(
	parameter int SLOTS = ssb_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssb_pkg::CFG_AW-1:0]  paddr,
	input  logic [ssb_pkg::DATA_W-1:0]  pwdata,
	output logic [ssb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	ssb_item_if.sink                    item,
	ssb_result_if.source                result
);
	import ssb_pkg::*;

	ssb_cmd_t          cmd;
	ssb_stat_t         stat;
	logic [AMT_W-1:0]  period_q;
	logic [AMT_W-1:0]  init_q;
	logic              reg_sel;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_AW-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_sel == REG_INIT) ? init_q : period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			init_q   <= BUDGET_RST;
		end else if (cfg_wr) begin
			if (reg_sel == REG_PERIOD) begin
				period_q <= pwdata;
			end else begin
				init_q <= pwdata;
			end
		end
	end

	ssb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_opcode (item.opcode),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ssb_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.in_now             (item.now_time),
		.in_amount          (item.amount),
		.period             (period_q),
		.granted            (result.granted),
		.budget_left        (result.budget_left),
		.refill_found       (result.refill_found),
		.next_refill_time   (result.next_refill_time),
		.next_refill_amount (result.next_refill_amount),
		.budget_underflow   (result.budget_underflow)
	);

endmodule

// ----- hw/rtl/ssb_ctrl.sv -----
// Controller state machine of the budget core: sequences capture, slot scan,
// grant or completion, and the output register. Depends on ssb_pkg and the macros.
`timescale 1ns / 1ps
`include "sporadic_server_budget_core_macros.svh"

module ssb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_opcode,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ssb_pkg::ssb_cmd_t  cmd,
	input  ssb_pkg::ssb_stat_t stat
);
	import ssb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_GRANT,
		ST_COMPL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.cap      = in_fire;
		cmd.fetch    = (state_q == ST_FETCH);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.grant    = (state_q == ST_GRANT);
		cmd.compl    = (state_q == ST_COMPL);
		cmd.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (in_opcode == OP_COMPL) ? ST_COMPL : ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (stat.eval_last) begin
						state_q <= ST_GRANT;
					end
				end
				ST_GRANT: begin
					state_q <= ST_DONE;
				end
				ST_COMPL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SSB_ASSERT_NEXT(a_accept_busy, in_fire, !in_ready, "ready high right after a transfer")
	`SSB_ASSERT_SAME(a_load_free, cmd.load_out, !out_valid_q || out_ready, "result overwritten")
	`SSB_ASSERT_NEXT(a_load_idle, cmd.load_out, state_q == ST_IDLE && out_valid_q, "no return to idle")

endmodule

// ----- hw/rtl/ssb_dp.sv -----
// Datapath of the budget core: slot memory, budget, slot pointer, scan and
// result registers. Depends on ssb_pkg and the macros.
`timescale 1ns / 1ps
`include "sporadic_server_budget_core_macros.svh"

module ssb_dp #(
	parameter int SLOTS = ssb_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ssb_pkg::ssb_cmd_t          cmd,
	output ssb_pkg::ssb_stat_t         stat,
	input  logic [ssb_pkg::TIME_W-1:0] in_now,
	input  logic [ssb_pkg::AMT_W-1:0]  in_amount,
	input  logic [ssb_pkg::AMT_W-1:0]  period,
	output logic                       granted,
	output logic [ssb_pkg::AMT_W-1:0]  budget_left,
	output logic                       refill_found,
	output logic [ssb_pkg::TIME_W-1:0] next_refill_time,
	output logic [ssb_pkg::AMT_W-1:0]  next_refill_amount,
	output logic                       budget_underflow
);
	import ssb_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

	logic [TIME_W-1:0] time_mem [SLOTS];
	logic [AMT_W-1:0]  amt_mem  [SLOTS];
	logic [SLOTS-1:0]  tvld_q;
	logic [SLOTS-1:0]  avld_q;

	logic [AMT_W-1:0]  budget_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  eval_idx_s1;
	logic [TIME_W-1:0] rd_time_s1;
	logic [AMT_W-1:0]  rd_amt_s1;
	logic [TIME_W-1:0] now_q;
	logic [AMT_W-1:0]  amt_q;

	logic              found_q;
	logic [IDX_W-1:0]  f_idx_q;
	logic [TIME_W-1:0] f_time_q;
	logic [AMT_W-1:0]  f_amt_q;
	logic [AMT_W-1:0]  p_amt_q;

	logic              res_granted_q;
	logic [AMT_W-1:0]  res_budget_q;
	logic              res_found_q;
	logic [TIME_W-1:0] res_time_q;
	logic [AMT_W-1:0]  res_amt_q;
	logic              res_under_q;

	logic              expired;
	logic [AMT_W:0]    refill_sum;
	logic [AMT_W-1:0]  refill_sat;
	logic              grant_ok;
	logic [TIME_W:0]   due_sum;
	logic [TIME_W-1:0] due_time;
	logic              use_ptr;
	logic              over_use;
	logic [IDX_W-1:0]  rd_idx_nxt;
	logic [IDX_W-1:0]  ptr_nxt;

	logic              wr_time_en;
	logic              wr_amt_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [TIME_W-1:0] wr_time;
	logic [AMT_W-1:0]  wr_amt;

	assign expired    = rd_time_s1 < now_q;
	assign refill_sum = {1'b0, budget_q} + {1'b0, rd_amt_s1};
	assign refill_sat = refill_sum[AMT_W] ? AMT_MAX : refill_sum[AMT_W-1:0];
	assign grant_ok   = budget_q >= amt_q;
	assign due_sum    = {1'b0, now_q} + {{(TIME_W + 1 - AMT_W){1'b0}}, period};
	assign due_time   = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];
	assign use_ptr    = grant_ok && (!found_q || ptr_q <= f_idx_q);
	assign over_use   = amt_q > budget_q;
	assign rd_idx_nxt = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
	assign ptr_nxt    = (ptr_q == IDX_LAST) ? '0 : ptr_q + 1'b1;

	assign stat.eval_last = (eval_idx_s1 == IDX_LAST);

	always_comb begin
		wr_time_en = 1'b0;
		wr_amt_en  = 1'b0;
		wr_idx     = ptr_q;
		wr_time    = '0;
		wr_amt     = amt_q;
		if (cmd.scan && expired) begin
			wr_time_en = 1'b1;
			wr_amt_en  = 1'b1;
			wr_idx     = eval_idx_s1;
			wr_amt     = '0;
		end else if (cmd.grant && grant_ok) begin
			wr_time_en = 1'b1;
			wr_time    = due_time;
		end else if (cmd.compl) begin
			wr_amt_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_time_en) begin
			time_mem[wr_idx] <= wr_time;
		end
		if (wr_amt_en) begin
			amt_mem[wr_idx] <= wr_amt;
		end
		rd_time_s1 <= tvld_q[rd_idx_q] ? time_mem[rd_idx_q] : '0;
		rd_amt_s1  <= avld_q[rd_idx_q] ? amt_mem[rd_idx_q] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q      <= '0;
			avld_q      <= '0;
			budget_q    <= BUDGET_RST;
			ptr_q       <= '0;
			rd_idx_q    <= '0;
			eval_idx_s1 <= '0;
			found_q     <= 1'b0;
			f_idx_q     <= '0;
		end else begin
			if (wr_time_en) begin
				tvld_q[wr_idx] <= 1'b1;
			end
			if (wr_amt_en) begin
				avld_q[wr_idx] <= 1'b1;
			end
			eval_idx_s1 <= rd_idx_q;
			if (cmd.cap) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
				f_idx_q  <= '0;
			end else if (cmd.fetch || cmd.scan) begin
				rd_idx_q <= rd_idx_nxt;
			end
			if (cmd.scan) begin
				if (expired) begin
					budget_q <= refill_sat;
				end else if (!found_q) begin
					found_q <= 1'b1;
					f_idx_q <= eval_idx_s1;
				end
			end
			if (cmd.compl) begin
				budget_q <= over_use ? '0 : budget_q - amt_q;
				ptr_q    <= ptr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			now_q    <= in_now;
			amt_q    <= in_amount;
			f_time_q <= '0;
			f_amt_q  <= '0;
			p_amt_q  <= '0;
		end
		if (cmd.scan) begin
			if (!expired && !found_q) begin
				f_time_q <= rd_time_s1;
				f_amt_q  <= rd_amt_s1;
			end
			if (eval_idx_s1 == ptr_q) begin
				p_amt_q <= expired ? '0 : rd_amt_s1;
			end
		end
		if (cmd.grant) begin
			res_granted_q <= grant_ok;
			res_budget_q  <= budget_q;
			res_found_q   <= use_ptr || found_q;
			res_time_q    <= use_ptr ? due_time : f_time_q;
			res_amt_q     <= use_ptr ? p_amt_q : f_amt_q;
			res_under_q   <= 1'b0;
		end
		if (cmd.compl) begin
			res_granted_q <= 1'b0;
			res_budget_q  <= over_use ? '0 : budget_q - amt_q;
			res_found_q   <= 1'b0;
			res_time_q    <= '0;
			res_amt_q     <= '0;
			res_under_q   <= over_use;
		end
		if (cmd.load_out) begin
			granted            <= res_granted_q;
			budget_left        <= res_budget_q;
			refill_found       <= res_found_q;
			next_refill_time   <= res_time_q;
			next_refill_amount <= res_amt_q;
			budget_underflow   <= res_under_q;
		end
	end

	`SSB_ASSERT_SAME(a_ptr_range, 1'b1, ptr_q <= IDX_LAST, "slot pointer out of range")
	`SSB_ASSERT_NEXT(a_compl_drain, cmd.compl, budget_q <= $past(budget_q), "completion grew budget")
	`SSB_ASSERT_NEXT(a_refill_grow, cmd.scan && expired, budget_q >= $past(budget_q),
		"refill shrank budget")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for sporadic_server_budget_core: an in-bench budget predictor, directed
// and random request/completion traffic, idle bursts on both channels and APB register access.
// Depends on ssb_pkg, the ssb_item_if / ssb_result_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import ssb_pkg::*;

	localparam int SLOT_COUNT  = SLOTS_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTS  = 30;

	typedef struct packed {
		logic               granted;
		logic [AMT_W-1:0]   budget_left;
		logic               refill_found;
		logic [TIME_W-1:0]  next_refill_time;
		logic [AMT_W-1:0]   next_refill_amount;
		logic               budget_underflow;
	} budget_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [CFG_AW-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	ssb_item_if   item_ch ();
	ssb_result_if result_ch ();

	sporadic_server_budget_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	// predicted server state
	logic [AMT_W-1:0]   model_period;
	logic [AMT_W-1:0]   model_init;
	logic [AMT_W-1:0]   model_budget;
	logic [TIME_W-1:0]  slot_time [SLOT_COUNT];
	logic [AMT_W-1:0]   slot_amount [SLOT_COUNT];
	int unsigned        slot_ptr;

	budget_result_t     pending_results[$];
	logic [TIME_W-1:0]  sim_now;

	logic idle_on;
	logic quiet_tail;
	logic hold_request;

	int err_count;
	int n_items;
	int n_requests;
	int n_grants;
	int n_denials;
	int n_underflows;
	int n_budget_sat;
	int n_time_sat;
	int n_checked;
	int n_holds;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
	endtask

	function automatic budget_result_t predict_budget(input logic op,
		input logic [TIME_W-1:0] now, input logic [AMT_W-1:0] amt);
		budget_result_t r;
		logic [AMT_W:0]  sum;
		logic [TIME_W:0] due;
		r = '0;
		if (op == OP_REQUEST) begin
			n_requests++;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slot_time[i] < now) begin
					sum = {1'b0, model_budget} + {1'b0, slot_amount[i]};
					if (sum[AMT_W]) begin
						model_budget = AMT_MAX;
						n_budget_sat++;
					end else begin
						model_budget = sum[AMT_W-1:0];
					end
					slot_time[i] = '0;
					slot_amount[i] = '0;
				end
			end
			if (model_budget >= amt) begin
				due = {1'b0, now} + {{(TIME_W-AMT_W+1){1'b0}}, model_period};
				if (due[TIME_W]) begin
					slot_time[slot_ptr] = TIME_MAX;
					n_time_sat++;
				end else begin
					slot_time[slot_ptr] = due[TIME_W-1:0];
				end
				r.granted = 1'b1;
				n_grants++;
			end else begin
				n_denials++;
			end
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (!r.refill_found && slot_time[i] >= now) begin
					r.refill_found = 1'b1;
					r.next_refill_time = slot_time[i];
					r.next_refill_amount = slot_amount[i];
				end
			end
		end else begin
			slot_amount[slot_ptr] = amt;
			if (amt > model_budget) begin
				model_budget = '0;
				r.budget_underflow = 1'b1;
				n_underflows++;
			end else begin
				model_budget = model_budget - amt;
			end
			slot_ptr = (slot_ptr + 1) % SLOT_COUNT;
		end
		r.budget_left = model_budget;
		return r;
	endfunction

	task automatic send_item(input logic op, input logic [TIME_W-1:0] now,
		input logic [AMT_W-1:0] amt, output budget_result_t pred);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.now_time <= now;
		item_ch.amount <= amt;
		do @(posedge clk); while (!item_ch.ready);
		pred = predict_budget(op, now, amt);
		pending_results.push_back(pred);
		n_items++;
	endtask

	task automatic drain_items;
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_read(input logic idx, output logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_PERIOD)
			model_period = value;
		else
			model_init = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apb_read(idx, rd);
		if (rd !== value)
			report_mismatch(idx == REG_PERIOD ? "period readback" : "init readback", rd, value);
	endtask

	function automatic void advance_clock();
		logic [63:0] adv;
		logic [63:0] sum;
		case ($urandom_range(0, 3))
			0: adv = 64'($urandom_range(0, 16));
			1: adv = 64'($urandom_range(0, model_period > 1000 ? 1000 : model_period));
			2: begin
				adv = {32'b0, model_period} + $urandom_range(0, 4);
				if (adv >= 2)
					adv = adv - 2;
			end
			default: adv = {$urandom, $urandom} % ({32'b0, model_period} * 2 + 1);
		endcase
		sum = {1'b0, sim_now} + adv;
		if (sum > {1'b0, TIME_MAX})
			sim_now = TIME_W'($urandom_range(0, 1000));
		else
			sim_now = sum[TIME_W-1:0];
	endfunction

	function automatic logic [AMT_W-1:0] pick_cost();
		case ($urandom_range(0, 5))
			4: return ($urandom_range(0, 1) != 0) ? model_budget : model_budget + 1;
			5: return $urandom;
			default: return $urandom_range(0, 120);
		endcase
	endfunction

	function automatic logic [AMT_W-1:0] pick_use(input logic [AMT_W-1:0] cost);
		case ($urandom_range(0, 5))
			4: return cost + $urandom_range(1, 200);
			5: return $urandom;
			default: return $urandom_range(0, cost);
		endcase
	endfunction

	always @(posedge clk) begin : result_check
		budget_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, 64'd0);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (result_ch.granted !== want.granted)
					report_mismatch("granted", result_ch.granted, want.granted);
				if (result_ch.budget_left !== want.budget_left)
					report_mismatch("budget_left", result_ch.budget_left, want.budget_left);
				if (result_ch.refill_found !== want.refill_found)
					report_mismatch("refill_found", result_ch.refill_found, want.refill_found);
				if (result_ch.next_refill_time !== want.next_refill_time)
					report_mismatch("next_refill_time", result_ch.next_refill_time,
						want.next_refill_time);
				if (result_ch.next_refill_amount !== want.next_refill_amount)
					report_mismatch("next_refill_amount", result_ch.next_refill_amount,
						want.next_refill_amount);
				if (result_ch.budget_underflow !== want.budget_underflow)
					report_mismatch("budget_underflow", result_ch.budget_underflow,
						want.budget_underflow);
			end
		end
	end

	initial begin : result_sink
		int hold_left;
		int stall_left;
		int window;
		hold_left = 0;
		stall_left = 0;
		window = 0;
		idle_on = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
				n_holds++;
			end
			if (window == 0) begin
				window = $urandom_range(64, 256);
				idle_on = ($urandom_range(0, 2) != 0);
			end else begin
				window--;
			end
			if (quiet_tail)
				idle_on = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_register_defaults;
		logic [DATA_W-1:0] rd;
		apb_read(REG_PERIOD, rd);
		if (rd !== PERIOD_RST)
			report_mismatch("period reset value", rd, PERIOD_RST);
		apb_read(REG_INIT, rd);
		if (rd !== BUDGET_RST)
			report_mismatch("init reset value", rd, BUDGET_RST);
	endtask

	task automatic test_directed_cases;
		budget_result_t p;
		// cleared slots at time zero, then no pending slot
		send_item(OP_REQUEST, '0, AMT_MAX, p);
		send_item(OP_REQUEST, 63'd1, AMT_MAX, p);
		send_item(OP_REQUEST, '0, '0, p);
		send_item(OP_REQUEST, 63'd5, 32'd301, p);
		send_item(OP_COMPL, '0, 32'd100, p);
		send_item(OP_COMPL, TIME_MAX, '0, p);
		send_item(OP_REQUEST, 63'd10, 32'd200, p);
		send_item(OP_COMPL, '0, AMT_MAX, p);
		// returned amounts overflow the budget
		send_item(OP_REQUEST, 63'd4000, 32'd1, p);
		send_item(OP_COMPL, '0, AMT_MAX, p);
		drain_items();
		write_register(REG_PERIOD, AMT_MAX);
		write_register(REG_INIT, '0);
		send_item(OP_REQUEST, TIME_MAX - 5, '0, p);
		send_item(OP_REQUEST, TIME_MAX, AMT_MAX, p);
		send_item(OP_COMPL, '0, 32'd7, p);
		drain_items();
		write_register(REG_PERIOD, '0);
		write_register(REG_INIT, AMT_MAX);
		send_item(OP_REQUEST, 63'd100, 32'd1, p);
		send_item(OP_COMPL, '0, 32'd3, p);
		send_item(OP_REQUEST, 63'd100, '0, p);
		send_item(OP_REQUEST, 63'd101, '0, p);
		send_item(OP_COMPL, '0, 32'd1, p);
		send_item(OP_COMPL, '0, 32'd2, p);
		send_item(OP_COMPL, '0, '0, p);
		send_item(OP_REQUEST, TIME_MAX, '0, p);
		drain_items();
		write_register(REG_PERIOD, PERIOD_RST);
		write_register(REG_INIT, BUDGET_RST);
		sim_now = 63'd200;
	endtask

	task automatic test_output_backpressure;
		budget_result_t p;
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++) begin
			advance_clock();
			send_item(OP_REQUEST, sim_now, pick_cost(), p);
			send_item(OP_COMPL, '0, $urandom_range(0, 80), p);
		end
		drain_items();
	endtask

	task automatic run_traffic(input int quota);
		budget_result_t p;
		logic [AMT_W-1:0] cost;
		int sent;
		int kind;
		sent = 0;
		while (sent < quota) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				advance_clock();
				cost = pick_cost();
				send_item(OP_REQUEST, sim_now, cost, p);
				sent++;
				if (p.granted || $urandom_range(0, 3) == 0) begin
					send_item(OP_COMPL, TIME_W'({$urandom, $urandom}), pick_use(cost), p);
					sent++;
				end else if (p.refill_found && p.next_refill_time != TIME_MAX &&
					$urandom_range(0, 1) != 0) begin
					sim_now = p.next_refill_time + 1;
				end
			end else if (kind == 7) begin
				send_item(OP_REQUEST, TIME_W'({$urandom, $urandom}), $urandom, p);
				sent++;
			end else if (kind == 8) begin
				send_item(OP_COMPL, TIME_W'({$urandom, $urandom}), $urandom, p);
				sent++;
			end else begin
				send_item(OP_REQUEST,
					($urandom_range(0, 3) == 0) ? '0 : slot_time[$urandom_range(0, SLOT_COUNT-1)],
					$urandom_range(0, 100), p);
				sent++;
			end
		end
		drain_items();
	endtask

	task automatic test_random_phases;
		write_register(REG_PERIOD, AMT_MAX);
		write_register(REG_INIT, $urandom);
		run_traffic(300);
		write_register(REG_PERIOD, 32'd1);
		run_traffic(300);
		write_register(REG_PERIOD, $urandom_range(2, 64));
		write_register(REG_INIT, $urandom_range(0, 1000));
		run_traffic(300);
		quiet_tail = 1'b1;
		write_register(REG_PERIOD, $urandom_range(500, 5000));
		run_traffic(320);
	endtask

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_REQUEST;
		item_ch.now_time = '0;
		item_ch.amount = '0;
		quiet_tail = 1'b0;
		hold_request = 1'b0;
		err_count = 0;
		n_items = 0;
		n_requests = 0;
		n_grants = 0;
		n_denials = 0;
		n_underflows = 0;
		n_budget_sat = 0;
		n_time_sat = 0;
		n_checked = 0;
		n_holds = 0;
		model_period = PERIOD_RST;
		model_init = BUDGET_RST;
		model_budget = BUDGET_RST;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_time[i] = '0;
			slot_amount[i] = '0;
		end
		slot_ptr = 0;
		sim_now = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_defaults();
		test_directed_cases();
		test_output_backpressure();
		test_random_phases();

		drain_items();
		repeat (16) @(posedge clk);
		$display("run covered %0d items: %0d requests, %0d grants, %0d denials, %0d results checked",
			n_items, n_requests, n_grants, n_denials, n_checked);
		$display("%0d underflows, %0d budget saturations, %0d refill time saturations, %0d holds",
			n_underflows, n_budget_sat, n_time_sat, n_holds);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
